// ----- rtl/aecp_pkg.sv -----
// aecp_pkg: shared types, character codes and the code point lookup
// for the terminal stream parser; no dependencies
package aecp_pkg;

	localparam int CUR_W    = 16;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int GLYPH_W  = 7;
	localparam int COLOUR_W = 4;
	localparam int PARAM_W  = 16;

	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_QUEST  = 8'h3f;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_M      = 8'h6d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_VAL  = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_VAL  = 8'he0;

	localparam logic [15:0] CP_FULL  = 16'h2588;
	localparam logic [15:0] CP_UPPER = 16'h2580;
	localparam logic [15:0] CP_LOWER = 16'h2584;
	localparam logic [15:0] CP_HLINE = 16'h2500;

	localparam logic [GLYPH_W-1:0] GLYPH_NONE  = 7'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_FULL  = 7'd1;
	localparam logic [GLYPH_W-1:0] GLYPH_UPPER = 7'd2;
	localparam logic [GLYPH_W-1:0] GLYPH_LOWER = 7'd3;
	localparam logic [GLYPH_W-1:0] GLYPH_DASH  = 7'h2d;

	localparam logic [COLOUR_W-1:0] FORE_DEFAULT = 4'd7;
	localparam logic [COLOUR_W-1:0] BACK_DEFAULT = 4'd0;
	localparam logic [PARAM_W-1:0]  PARAM_MAX    = 16'hffff;
	localparam logic [CUR_W-1:0]    CUR_MAX      = 16'hffff;

	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	typedef enum logic [1:0] {
		MODE_GROUND = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIGIT,
		ST_ROW,
		ST_COL,
		ST_SGR,
		ST_EMIT
	} state_t;

	typedef enum logic {
		ALU_MAC,
		ALU_SGR
	} alu_op_t;

	typedef struct packed {
		alu_op_t             op;
		logic [PARAM_W-1:0]  operand;
		logic [3:0]          digit;
	} alu_req_t;

	typedef struct packed {
		logic [PARAM_W-1:0]  value;
		logic                fore_set;
		logic                back_set;
		logic [COLOUR_W-1:0] colour;
	} alu_res_t;

	typedef struct packed {
		logic                kind;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [GLYPH_W-1:0]  glyph;
		logic [COLOUR_W-1:0] fore;
		logic [COLOUR_W-1:0] back;
	} res_t;

	function automatic logic [GLYPH_W-1:0] utf_glyph(input logic [15:0] cp);
		logic [GLYPH_W-1:0] g;
		unique case (cp)
			CP_FULL:  g = GLYPH_FULL;
			CP_UPPER: g = GLYPH_UPPER;
			CP_LOWER: g = GLYPH_LOWER;
			CP_HLINE: g = GLYPH_DASH;
			default:  g = GLYPH_NONE;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/ansi_escape_cell_parser.sv -----
// ansi_escape_cell_parser: one byte beat in, at most one result beat out;
// an accepted byte is decoded, then a cell goes to emit, a csi digit to a
// digit step, csi H or f to row and col (and emit for a boundary), csi m to
// one sgr step per parameter; a new byte is taken only back in idle, results
// are registered at emit, a stalled result holds the sequencer; reset clears the
// parser, cursor and colour state at once but not the csi parameter registers
module ansi_escape_cell_parser #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 24,
	parameter int MAX_PARAMS  = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic [aecp_pkg::ROW_W-1:0]         cell_row,
	output logic [aecp_pkg::COL_W-1:0]         cell_col,
	output logic [aecp_pkg::GLYPH_W-1:0]       glyph,
	output logic [aecp_pkg::COLOUR_W-1:0]      fore_colour,
	output logic [aecp_pkg::COLOUR_W-1:0]      back_colour
);
	import aecp_pkg::*;

	localparam int CW   = $clog2(MAX_PARAMS + 1);
	localparam int IDXW = $clog2(MAX_PARAMS);

	logic               out_valid_q;
	res_t               out_q;
	logic               out_free, load;
	res_t               res;
	logic               pf_wr;
	logic [IDXW-1:0]    pf_wr_idx, pf_rd_idx;
	logic [PARAM_W-1:0] pf_wr_data, pf_rd_data;
	alu_req_t           alu_req;
	alu_res_t           alu_res;

	assign out_free = !out_valid_q || !out_stall;

	aecp_ctrl #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS),
		.MAX_PARAMS  (MAX_PARAMS),
		.CW          (CW),
		.IDXW        (IDXW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_free   (out_free),
		.load       (load),
		.res        (res),
		.pf_wr      (pf_wr),
		.pf_wr_idx  (pf_wr_idx),
		.pf_wr_data (pf_wr_data),
		.pf_rd_idx  (pf_rd_idx),
		.pf_rd_data (pf_rd_data),
		.alu_req    (alu_req),
		.alu_res    (alu_res)
	);

	aecp_param_file #(
		.DEPTH (MAX_PARAMS),
		.IDXW  (IDXW)
	) u_params (
		.clk     (clk),
		.wr_en   (pf_wr),
		.wr_idx  (pf_wr_idx),
		.wr_data (pf_wr_data),
		.rd_idx  (pf_rd_idx),
		.rd_data (pf_rd_data)
	);

	aecp_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign cell_row    = out_q.row;
	assign cell_col    = out_q.col;
	assign glyph       = out_q.glyph;
	assign fore_colour = out_q.fore;
	assign back_colour = out_q.back;

	// a result never overwrites a beat still waiting downstream
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result loaded over a pending beat");

	// an accepted byte keeps the input side stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// frame boundary beats carry zero fields
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME |-> cell_row == '0 && cell_col == '0
			&& glyph == '0 && fore_colour == '0 && back_colour == '0)
		else $error("frame boundary with nonzero fields");

	// a cell write always carries a glyph
	a_cell_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CELL |-> glyph != GLYPH_NONE)
		else $error("cell write without glyph");

endmodule

// ----- rtl/aecp_param_file.sv -----
// aecp_param_file: csi parameter registers, one write and one read port
// depends on aecp_pkg for the parameter width
module aecp_param_file #(
	parameter int DEPTH = 8,
	parameter int IDXW  = 3
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDXW-1:0]             wr_idx,
	input  logic [aecp_pkg::PARAM_W-1:0] wr_data,
	input  logic [IDXW-1:0]             rd_idx,
	output logic [aecp_pkg::PARAM_W-1:0] rd_data
);
	import aecp_pkg::*;

	logic [PARAM_W-1:0] regs_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = regs_q[rd_idx];

endmodule

// ----- rtl/aecp_alu.sv -----
// aecp_alu: shared unit for decimal accumulate (x10 plus digit, saturating)
// and sgr colour classification; depends on aecp_pkg
module aecp_alu (
	input  aecp_pkg::alu_req_t req,
	output aecp_pkg::alu_res_t res
);
	import aecp_pkg::*;

	logic [19:0] mac;
	logic [15:0] v;
	logic [15:0] d30, d90, d40, d100;

	assign v    = req.operand;
	assign mac  = {v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, req.digit};
	assign d30  = v - 16'd30;
	assign d90  = v - 16'd90;
	assign d40  = v - 16'd40;
	assign d100 = v - 16'd100;

	always_comb begin
		res = '0;
		unique case (req.op)
			ALU_MAC: begin
				res.value = (mac > {4'd0, PARAM_MAX}) ? PARAM_MAX : mac[15:0];
			end
			ALU_SGR: begin
				res.value = v;
				if (v >= 16'd30 && v <= 16'd37) begin
					res.fore_set = 1'b1;
					res.colour   = {1'b0, d30[2:0]};
				end else if (v >= 16'd90 && v <= 16'd97) begin
					res.fore_set = 1'b1;
					res.colour   = {1'b1, d90[2:0]};
				end else if (v >= 16'd40 && v <= 16'd47) begin
					res.back_set = 1'b1;
					res.colour   = {1'b0, d40[2:0]};
				end else if (v >= 16'd100 && v <= 16'd107) begin
					res.back_set = 1'b1;
					res.colour   = {1'b1, d100[2:0]};
				end
			end
			default: res = '0;
		endcase
	end

endmodule

// ----- rtl/aecp_ctrl.sv -----
// aecp_ctrl: byte sequencer holding parser, utf-8, cursor and colour state;
// drives the parameter file and the shared alu; depends on aecp_pkg
module aecp_ctrl #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 24,
	parameter int MAX_PARAMS  = 8,
	parameter int CW          = 4,
	parameter int IDXW        = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   data_byte,
	input  logic                         out_free,
	output logic                         load,
	output aecp_pkg::res_t               res,
	output logic                         pf_wr,
	output logic [IDXW-1:0]              pf_wr_idx,
	output logic [aecp_pkg::PARAM_W-1:0] pf_wr_data,
	output logic [IDXW-1:0]              pf_rd_idx,
	input  logic [aecp_pkg::PARAM_W-1:0] pf_rd_data,
	output aecp_pkg::alu_req_t           alu_req,
	input  aecp_pkg::alu_res_t           alu_res
);
	import aecp_pkg::*;

	state_t              state_q, state_d;
	mode_t               mode_q;
	logic [7:0]          byte_q;
	logic [CW-1:0]       cnt_q;
	logic                priv_q;
	logic [COLOUR_W-1:0] fore_q, back_q;
	logic [1:0]          utf_rem_q;
	logic [15:0]         utf_acc_q;
	logic [CUR_W-1:0]    cur_col_q, cur_row_q;
	logic [PARAM_W-1:0]  row_q;
	logic [IDXW-1:0]     idx_q;
	res_t                res_q;

	logic [15:0]         utf_acc_nx;
	logic [GLYPH_W-1:0]  utf_g, cell_glyph;
	logic                in_utf, is_digit, is_print, is_home, cell_req, on_screen;
	logic                sgr_last, sgr_reset;
	logic [CW-1:0]       cnt_last;
	logic [PARAM_W-1:0]  row_sel, col_sel;
	state_t              dec_next;

	// byte decode
	always_comb begin
		utf_acc_nx = {utf_acc_q[9:0], byte_q[5:0]};
		utf_g      = utf_glyph(utf_acc_nx);
		in_utf     = utf_rem_q != 2'd0;
		is_digit   = byte_q >= CH_ZERO && byte_q <= CH_NINE;
		is_print   = byte_q >= CH_SPACE && byte_q < CH_DEL;
		is_home    = (byte_q == CH_H || byte_q == CH_F) && !priv_q;
		if (in_utf) begin
			cell_req   = utf_rem_q == 2'd1 && utf_g != GLYPH_NONE;
			cell_glyph = utf_g;
		end else begin
			cell_req   = mode_q != MODE_ESC && mode_q != MODE_CSI && is_print;
			cell_glyph = byte_q[6:0];
		end
		on_screen = cur_row_q < CUR_W'(SCREEN_ROWS) && cur_col_q < CUR_W'(SCREEN_COLS);
		cnt_last  = cnt_q - CW'(1);
		sgr_last  = CW'(idx_q) == cnt_last;
		sgr_reset = cnt_q == CW'(1) && pf_rd_data == '0;
		row_sel   = (cnt_q >= CW'(1) && pf_rd_data != '0) ? pf_rd_data : PARAM_W'(1);
		col_sel   = (cnt_q >= CW'(2) && pf_rd_data != '0) ? pf_rd_data : PARAM_W'(1);
	end

	always_comb begin
		dec_next = ST_IDLE;
		if (in_utf) begin
			dec_next = (cell_req && on_screen) ? ST_EMIT : ST_IDLE;
		end else begin
			unique case (mode_q)
				MODE_ESC: dec_next = ST_IDLE;
				MODE_CSI: begin
					if (is_digit) begin
						dec_next = ST_DIGIT;
					end else if (byte_q == CH_SEMI || byte_q == CH_QUEST) begin
						dec_next = ST_IDLE;
					end else if (is_home) begin
						dec_next = ST_ROW;
					end else if (byte_q == CH_M && cnt_q != '0) begin
						dec_next = ST_SGR;
					end
				end
				default: dec_next = (cell_req && on_screen) ? ST_EMIT : ST_IDLE;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   state_d = in_valid ? ST_DECODE : ST_IDLE;
			ST_DECODE: state_d = dec_next;
			ST_DIGIT:  state_d = ST_IDLE;
			ST_ROW:    state_d = ST_COL;
			ST_COL: begin
				state_d = (row_q == PARAM_W'(1) && col_sel == PARAM_W'(1)) ? ST_EMIT : ST_IDLE;
			end
			ST_SGR:    state_d = sgr_last ? ST_IDLE : ST_SGR;
			ST_EMIT:   state_d = out_free ? ST_IDLE : ST_EMIT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall   = state_q != ST_IDLE;
		load       = state_q == ST_EMIT && out_free;
		res        = res_q;
		pf_wr      = 1'b0;
		pf_wr_idx  = '0;
		pf_wr_data = '0;
		pf_rd_idx  = '0;
		alu_req.op      = (state_q == ST_SGR) ? ALU_SGR : ALU_MAC;
		alu_req.operand = pf_rd_data;
		alu_req.digit   = byte_q[3:0];
		unique case (state_q)
			ST_DECODE: begin
				if (!in_utf && mode_q == MODE_ESC && byte_q == CH_LBRACK) begin
					pf_wr = 1'b1;
				end else if (!in_utf && mode_q == MODE_CSI && byte_q == CH_SEMI
						&& cnt_q < CW'(MAX_PARAMS)) begin
					pf_wr     = 1'b1;
					pf_wr_idx = cnt_q[IDXW-1:0];
				end
			end
			ST_DIGIT: begin
				pf_rd_idx  = cnt_last[IDXW-1:0];
				pf_wr      = 1'b1;
				pf_wr_idx  = cnt_last[IDXW-1:0];
				pf_wr_data = alu_res.value;
			end
			ST_ROW:  pf_rd_idx = IDXW'(0);
			ST_COL:  pf_rd_idx = IDXW'(1);
			ST_SGR:  pf_rd_idx = idx_q;
			default: pf_rd_idx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_GROUND;
			cnt_q      <= '0;
			priv_q     <= 1'b0;
			fore_q     <= FORE_DEFAULT;
			back_q     <= BACK_DEFAULT;
			utf_rem_q  <= 2'd0;
			utf_acc_q  <= '0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DECODE: begin
					idx_q <= '0;
					if (in_utf) begin
						utf_acc_q  <= utf_acc_nx;
						utf_rem_q  <= utf_rem_q - 2'd1;
						if (cell_req && cur_col_q != CUR_MAX) begin
							cur_col_q <= cur_col_q + CUR_W'(1);
						end
					end else begin
						unique case (mode_q)
							MODE_ESC: begin
								if (byte_q == CH_LBRACK) begin
									mode_q <= MODE_CSI;
									cnt_q  <= '0;
									priv_q <= 1'b0;
								end else begin
									mode_q <= MODE_GROUND;
								end
							end
							MODE_CSI: begin
								if (is_digit) begin
									if (cnt_q == '0) begin
										cnt_q <= CW'(1);
									end
								end else if (byte_q == CH_SEMI) begin
									if (cnt_q < CW'(MAX_PARAMS)) begin
										cnt_q <= cnt_q + CW'(1);
									end
								end else if (byte_q == CH_QUEST) begin
									priv_q <= 1'b1;
								end else begin
									mode_q <= MODE_GROUND;
									if (!is_home && byte_q == CH_M && cnt_q == '0) begin
										fore_q <= FORE_DEFAULT;
										back_q <= BACK_DEFAULT;
									end
								end
							end
							default: begin
								if (byte_q == CH_ESC) begin
									mode_q <= MODE_ESC;
								end else if (cell_req) begin
									if (cur_col_q != CUR_MAX) begin
										cur_col_q <= cur_col_q + CUR_W'(1);
									end
								end else if ((byte_q & LEAD2_MASK) == LEAD2_VAL) begin
									utf_rem_q  <= 2'd1;
									utf_acc_q  <= {11'd0, byte_q[4:0]};
								end else if ((byte_q & LEAD3_MASK) == LEAD3_VAL) begin
									utf_rem_q  <= 2'd2;
									utf_acc_q  <= {12'd0, byte_q[3:0]};
								end
							end
						endcase
					end
				end
				ST_COL: begin
					cur_row_q <= row_q - PARAM_W'(1);
					cur_col_q <= col_sel - PARAM_W'(1);
				end
				ST_SGR: begin
					idx_q <= idx_q + IDXW'(1);
					if (sgr_reset) begin
						fore_q <= FORE_DEFAULT;
						back_q <= BACK_DEFAULT;
					end else if (alu_res.fore_set) begin
						fore_q <= alu_res.colour;
					end else if (alu_res.back_set) begin
						back_q <= alu_res.colour;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			byte_q <= data_byte;
		end
		if (state_q == ST_ROW) begin
			row_q <= row_sel;
		end
		if (state_q == ST_DECODE) begin
			res_q <= '{kind: KIND_CELL, row: cur_row_q[ROW_W-1:0],
				col: cur_col_q[COL_W-1:0], glyph: cell_glyph, fore: fore_q, back: back_q};
		end else if (state_q == ST_COL) begin
			res_q <= '{kind: KIND_FRAME, default: '0};
		end
	end

endmodule
